@@ rtl/core/rlac_pkg.sv @@
// Package: constants, codes and types for the route lookup / ARP cache unit.
package rlac_pkg;
  localparam int unsigned NumAdapters = 4;
  localparam int unsigned RouteDepth  = 16;
  localparam int unsigned ArpDepth    = 32;
  localparam int unsigned RouteAw     = (RouteDepth > 1) ? $clog2(RouteDepth) : 1;
  localparam int unsigned ArpAw       = (ArpDepth > 1) ? $clog2(ArpDepth) : 1;
  localparam int unsigned RouteCw     = $clog2(RouteDepth + 1);
  localparam int unsigned ArpCw       = $clog2(ArpDepth + 1);

  typedef enum logic [1:0] {
    FuncAddRoute = 2'd0,
    FuncAddArp   = 2'd1,
    FuncGetRoute = 2'd2,
    FuncNone     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoRoute  = 3'd1,
    StArpMiss  = 3'd2,
    StLoopback = 3'd3,
    StFull     = 3'd4,
    StDup      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    SIdle, SRoute, SDecide, SArp, SFinish, SOut
  } state_e;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] gw;
    logic [31:0] mask;
    logic [2:0]  adp;
  } route_t;
endpackage

@@ rtl/core/route_lookup_arp_cache_unit.sv @@
// Top level: route table and ARP cache with a sequenced lookup over two memories.
// Usage:
//  Input channel (in_valid_i / in_stall_o) takes one word: func plus operands.
//  Output channel (out_valid_o / out_stall_i) gives one result word per item.
//  Config is an APB-style port; adapter i ip at 8*i, mask at 8*i + 4, read back.
// Sequence: one item at a time. Func 3 and loopback answers are registered on
//  acceptance; add route writes the table unless full; add ARP scans the ARP
//  cache for its IP, then writes unless a duplicate or full; get route scans the
//  route table (skipped when an adapter subnet matches), picks the next hop and,
//  if one is found, scans the ARP cache; each scan ends sooner on an exact route
//  or ARP hit. Scans read one entry per cycle from each memory; the adapter
//  check is done in the accepting cycle.
// Reset empties both tables (counts to zero); memories need no clearing.
// A result waits in the output register while out_stall_i is high; the next
// item is taken once the result has been delivered.
module route_lookup_arp_cache_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] ip_addr_i,
  input  logic [31:0] src_or_gateway_i,
  input  logic [31:0] route_mask_i,
  input  logic [47:0] mac_addr_i,
  input  logic [1:0]  adapter_index_i,
  input  logic        adapter_given_i,
  input  logic        allow_broadcast_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [47:0] mac_out_o,
  output logic [1:0]  out_adapter_o,
  output logic        out_adapter_valid_o,
  output logic [31:0] hop_addr_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rlac_pkg::*;

  // config registers
  logic [31:0] cfg_q [8];
  assign pready = 1'b1;
  assign prdata = cfg_q[paddr[4:2]];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) cfg_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      cfg_q[paddr[4:2]] <= pwdata;
    end
  end

  state_e state_q, state_d;
  logic [RouteCw-1:0] rcnt_q;
  logic [ArpCw-1:0]   acnt_q;
  logic [RouteCw-1:0] ri_q;
  logic [ArpCw-1:0]   ai_q;
  logic rrd_q, ard_q;  // read issued last cycle

  // captured word
  logic [1:0]  func_q;
  logic [31:0] dst_q, sog_q, msk_q;
  logic [47:0] mac_q;
  logic [1:0]  pref_q;
  logic        pok_q, bc_q;

  // lookup progress
  logic        adf_q, exo_q, pfo_q, dfo_q;
  logic [1:0]  ads_q;
  route_t      ex_q, pf_q, df_q;
  logic [31:0] hop_q;
  logic [1:0]  uad_q;
  logic        uok_q;
  logic        hit_q;
  logic [47:0] hmac_q;

  // result register
  logic        ov_q;
  logic [2:0]  st_q;
  logic [47:0] mo_q;
  logic [1:0]  oa_q;
  logic        oav_q;
  logic [31:0] nh_q;

  // memories
  route_t      rmem [RouteDepth];
  logic [31:0] aipm [ArpDepth];
  logic [47:0] amacm [ArpDepth];
  route_t      rrd;
  logic [31:0] aip_rd;
  logic [47:0] amac_rd;

  logic accept;
  assign in_stall_o = (state_q != SIdle);
  assign accept = in_valid_i && !in_stall_o;

  logic rwr, awr;
  assign rwr = (state_q == SFinish) && (func_q == FuncAddRoute)
               && (rcnt_q < RouteCw'(RouteDepth));
  assign awr = (state_q == SFinish) && (func_q == FuncAddArp) && !hit_q
               && (acnt_q < ArpCw'(ArpDepth));

  always_ff @(posedge clk_i) begin
    if (rwr) rmem[rcnt_q[RouteAw-1:0]] <= route_t'{dst_q, sog_q, msk_q,
                                                  {pok_q, pref_q}};
    rrd <= rmem[ri_q[RouteAw-1:0]];
  end
  always_ff @(posedge clk_i) begin
    if (awr) begin
      aipm[acnt_q[ArpAw-1:0]]  <= dst_q;
      amacm[acnt_q[ArpAw-1:0]] <= mac_q;
    end
    aip_rd  <= aipm[ai_q[ArpAw-1:0]];
    amac_rd <= amacm[ai_q[ArpAw-1:0]];
  end

  // adapter check, combinational over four adapters
  logic        lb, adf;
  logic [1:0]  ads;
  always_comb begin
    logic done;
    lb = 1'b0; adf = 1'b0; ads = '0; done = 1'b0;
    for (int i = 0; i < NumAdapters; i++) begin
      logic [31:0] aip, am;
      aip = cfg_q[2*i]; am = cfg_q[2*i+1];
      if (!done) begin
        if (aip == ip_addr_i) begin
          lb = 1'b1; done = 1'b1;
        end else if (!(aip == '0 && !adapter_given_i)
                     && !(src_or_gateway_i != '0 && src_or_gateway_i != aip)
                     && ((am & ip_addr_i) == (aip & am))
                     && (!adapter_given_i || adapter_index_i == 2'(i))) begin
          adf = 1'b1; ads = 2'(i); done = 1'b1;
        end
      end
    end
  end

  // route selection after scan
  route_t sel;
  always_comb sel = exo_q ? ex_q : (pfo_q ? pf_q : df_q);

  logic rscan_done, ascan_done;
  assign rscan_done = !rrd_q && (ri_q >= rcnt_q);
  assign ascan_done = hit_q || (!ard_q && (ai_q >= acnt_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (accept) begin
        unique case (func_i)
          FuncAddRoute: state_d = SFinish;
          FuncAddArp:   state_d = SArp;
          FuncGetRoute: state_d = lb ? SOut : (adf ? SDecide : SRoute);
          default:      state_d = SOut;
        endcase
      end
      SRoute:  if (rscan_done || (rrd_q && rrd.dest == dst_q)) state_d = SDecide;
      SDecide: state_d = (!adf_q && !exo_q && !pfo_q && !dfo_q) ? SOut
                 : SArp;
      SArp:    if (ascan_done) state_d = SFinish;
      SFinish: state_d = SOut;
      SOut:    if (!ov_q || !out_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; rcnt_q <= '0; acnt_q <= '0; ov_q <= 1'b0;
      ri_q <= '0; ai_q <= '0; rrd_q <= 1'b0; ard_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rwr) rcnt_q <= rcnt_q + 1'b1;
      if (awr) acnt_q <= acnt_q + 1'b1;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (state_q == SFinish || (state_q == SIdle && accept && state_d == SOut))
        ov_q <= 1'b1;
      if (state_q == SDecide && state_d == SOut) ov_q <= 1'b1;
      // scan index and read-issued flags
      rrd_q <= (state_q == SRoute) && (ri_q < rcnt_q) && (state_d == SRoute);
      ard_q <= (state_q == SArp) && (ai_q < acnt_q) && !hit_q
               && !(ard_q && aip_rd == hop_q);
      if (state_q == SIdle) begin ri_q <= '0; ai_q <= '0; end
      if (state_q == SRoute && ri_q < rcnt_q) ri_q <= ri_q + 1'b1;
      if (state_q == SArp && ai_q < acnt_q && !hit_q) ai_q <= ai_q + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i; dst_q <= ip_addr_i; sog_q <= src_or_gateway_i;
      msk_q <= route_mask_i; mac_q <= mac_addr_i; pref_q <= adapter_index_i;
      pok_q <= adapter_given_i; bc_q <= allow_broadcast_i;
      adf_q <= adf; ads_q <= ads;
      exo_q <= 1'b0; pfo_q <= 1'b0; dfo_q <= 1'b0; hit_q <= 1'b0;
      hop_q <= ip_addr_i;  // ARP add searches its own IP
      // loopback only answers a route request
      st_q <= (func_i == FuncGetRoute && lb) ? StLoopback : StOk;
      mo_q <= '0; oa_q <= '0; oav_q <= 1'b0; nh_q <= '0;
    end
    // route scan
    if (state_q == SRoute && rrd_q) begin
      if (rrd.dest == dst_q) begin
        exo_q <= 1'b1; ex_q <= rrd;
      end else if (rrd.dest == '0) begin
        if (!pok_q || (rrd.adp[2] && rrd.adp[1:0] == pref_q)) begin
          dfo_q <= 1'b1; df_q <= rrd;
        end
      end else if ((dst_q & rrd.mask) == (rrd.dest & rrd.mask)) begin
        if (!pfo_q || rrd.mask > pf_q.mask) begin
          pfo_q <= 1'b1; pf_q <= rrd;
        end
      end
    end
    // pick next hop; no route answers here
    if (state_q == SDecide) begin
      if (!adf_q && !exo_q && !pfo_q && !dfo_q) begin
        st_q <= StNoRoute;
      end else begin
        hop_q <= adf_q ? dst_q : sel.gw;
        uad_q <= adf_q ? ads_q : sel.adp[1:0];
        uok_q <= adf_q ? 1'b1 : sel.adp[2];
      end
    end
    // ARP scan
    if (state_q == SArp && ard_q && !hit_q && aip_rd == hop_q) begin
      hit_q <= 1'b1; hmac_q <= amac_rd;
    end
    // build the result word
    if (state_q == SFinish) begin
      unique case (func_q)
        FuncAddRoute: st_q <= (rcnt_q < RouteCw'(RouteDepth)) ? StOk : StFull;
        FuncAddArp:   st_q <= hit_q ? StDup
                              : ((acnt_q < ArpCw'(ArpDepth)) ? StOk : StFull);
        default: begin
          if (bc_q && dst_q == '1 && (!pok_q || (uok_q && uad_q == pref_q))) begin
            st_q <= StOk; mo_q <= '1;
            oa_q <= uok_q ? uad_q : 2'd0; oav_q <= uok_q;
          end else if (hit_q) begin
            st_q <= StOk; mo_q <= hmac_q;
            oa_q <= uok_q ? uad_q : 2'd0; oav_q <= uok_q;
          end else if (!uok_q) begin
            st_q <= StNoRoute;
          end else begin
            st_q <= StArpMiss; oa_q <= uad_q; oav_q <= 1'b1; nh_q <= hop_q;
          end
        end
      endcase
    end
  end

  assign out_valid_o         = ov_q;
  assign status_o            = st_q;
  assign mac_out_o           = mo_q;
  assign out_adapter_o       = oa_q;
  assign out_adapter_valid_o = oav_q;
  assign hop_addr_o          = nh_q;
endmodule

@@ bench/tb_route_lookup_arp_cache_unit.sv @@
// Testbench for the route lookup / ARP cache unit: directed table plus random lookups.
module tb_route_lookup_arp_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rlac_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 305;

  typedef struct packed {
    func_e       func;
    logic [31:0] ip;
    logic [31:0] sg;
    logic [31:0] rmask;
    logic [47:0] mac;
    logic [1:0]  idx;
    logic        given;
    logic        bcast;
  } word_t;

  typedef struct packed {
    status_e     st;
    logic [47:0] mac;
    logic [1:0]  ad;
    logic        adv;
    logic [31:0] hop;
  } answer_t;

  typedef struct packed {
    word_t   w;
    logic    typed;
    answer_t ans;
  } row_t;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  word_t       cur = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [47:0] mac_out;
  logic [1:0]  out_adapter;
  logic        out_adapter_valid;
  logic [31:0] hop_addr;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  route_lookup_arp_cache_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(cur.func), .ip_addr_i(cur.ip), .src_or_gateway_i(cur.sg),
    .route_mask_i(cur.rmask), .mac_addr_i(cur.mac), .adapter_index_i(cur.idx),
    .adapter_given_i(cur.given), .allow_broadcast_i(cur.bcast),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .mac_out_o(mac_out), .out_adapter_o(out_adapter),
    .out_adapter_valid_o(out_adapter_valid), .hop_addr_o(hop_addr),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the block's state
  logic [31:0] adp_ip [4];
  logic [31:0] adp_mask [4];
  logic [31:0] rt_dest [RouteDepth];
  logic [31:0] rt_gw [RouteDepth];
  logic [31:0] rt_mask [RouteDepth];
  logic [2:0]  rt_adp [RouteDepth];
  int          rt_cnt = 0;
  logic [31:0] arp_ip [ArpDepth];
  logic [47:0] arp_mac [ArpDepth];
  int          arp_cnt = 0;

  answer_t pending_answers[$];
  row_t    dir_rows[$];
  int      errors = 0;
  bit      hold_req = 1'b0;

  function automatic void add_row(row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic answer_t mk_ans(status_e st, logic [47:0] mac, logic [1:0] ad,
                                     logic adv, logic [31:0] hop);
    answer_t a;
    a.st = st;
    a.mac = mac;
    a.ad = adv ? ad : 2'd0;
    a.adv = adv;
    a.hop = hop;
    return a;
  endfunction

  function automatic int arp_slot(logic [31:0] ip);
    for (int i = 0; i < arp_cnt; i++)
      if (arp_ip[i] == ip) return i;
    return -1;
  endfunction

  // Route request: adapter subnets, then exact, longest mask, default route
  function automatic answer_t route_answer(word_t w);
    logic ad_found, ex_ok, pf_ok, df_ok, use_ok;
    int ad_sel, ex, pf, df, ent, hit;
    logic [1:0] use_ad;
    logic [31:0] hop;
    ad_found = 0; ex_ok = 0; pf_ok = 0; df_ok = 0;
    ad_sel = 0; ex = 0; pf = 0; df = 0;
    for (int i = 0; i < NumAdapters; i++) begin
      if (adp_ip[i] == w.ip) return mk_ans(StLoopback, '0, '0, 1'b0, '0);
      if (adp_ip[i] == 0 && !w.given) continue;
      if (w.sg != 0 && w.sg != adp_ip[i]) continue;
      if ((adp_mask[i] & w.ip) == (adp_ip[i] & adp_mask[i]) && (!w.given || i == w.idx)) begin
        ad_found = 1;
        ad_sel = i;
        break;
      end
    end
    for (int i = 0; i < rt_cnt; i++) begin
      if (rt_dest[i] == w.ip) begin
        ex_ok = 1;
        ex = i;
        break;
      end
      if (rt_dest[i] == 0) begin
        if (!w.given || (rt_adp[i][2] && rt_adp[i][1:0] == w.idx)) begin
          df_ok = 1;
          df = i;
        end
      end else if ((w.ip & rt_mask[i]) == (rt_dest[i] & rt_mask[i])) begin
        if (!pf_ok || rt_mask[i] > rt_mask[pf]) begin
          pf_ok = 1;
          pf = i;
        end
      end
    end
    if (!ad_found && !ex_ok && !pf_ok && !df_ok) return mk_ans(StNoRoute, '0, '0, 1'b0, '0);
    if (ad_found) begin
      use_ad = ad_sel[1:0];
      use_ok = 1;
      hop = w.ip;
    end else begin
      ent = ex_ok ? ex : (pf_ok ? pf : df);
      use_ok = rt_adp[ent][2];
      use_ad = rt_adp[ent][1:0];
      hop = rt_gw[ent];
    end
    if (w.bcast && w.ip == '1 && (!w.given || (use_ok && use_ad == w.idx)))
      return mk_ans(StOk, '1, use_ad, use_ok, '0);
    hit = arp_slot(hop);
    if (hit >= 0) return mk_ans(StOk, arp_mac[hit], use_ad, use_ok, '0);
    if (!use_ok) return mk_ans(StNoRoute, '0, '0, 1'b0, '0);
    return mk_ans(StArpMiss, '0, use_ad, 1'b1, hop);
  endfunction

  // Applies one word to the shadow state and gives its answer
  function automatic answer_t lookup_answer(word_t w);
    case (w.func)
      FuncAddRoute: begin
        if (rt_cnt >= RouteDepth) return mk_ans(StFull, '0, '0, 1'b0, '0);
        rt_dest[rt_cnt] = w.ip;
        rt_gw[rt_cnt] = w.sg;
        rt_mask[rt_cnt] = w.rmask;
        rt_adp[rt_cnt] = w.given ? {1'b1, w.idx} : 3'd0;
        rt_cnt++;
        return mk_ans(StOk, '0, '0, 1'b0, '0);
      end
      FuncAddArp: begin
        if (arp_slot(w.ip) >= 0) return mk_ans(StDup, '0, '0, 1'b0, '0);
        if (arp_cnt >= ArpDepth) return mk_ans(StFull, '0, '0, 1'b0, '0);
        arp_ip[arp_cnt] = w.ip;
        arp_mac[arp_cnt] = w.mac;
        arp_cnt++;
        return mk_ans(StOk, '0, '0, 1'b0, '0);
      end
      FuncGetRoute: return route_answer(w);
      default: return mk_ans(StOk, '0, '0, 1'b0, '0);
    endcase
  endfunction

  function automatic word_t mk_word(func_e f, logic [31:0] ip, logic [31:0] sg,
                                    logic [31:0] rm, logic [47:0] mac, logic [1:0] idx,
                                    logic given, logic bc);
    word_t w;
    w.func = f; w.ip = ip; w.sg = sg; w.rmask = rm; w.mac = mac;
    w.idx = idx; w.given = given; w.bcast = bc;
    return w;
  endfunction

  function automatic logic [31:0] prefix_mask(int n);
    return (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - n));
  endfunction

  // Pick an address likely to hit something stored
  function automatic logic [31:0] pick_ip();
    int k, j;
    k = $urandom_range(0, 9);
    case (k)
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: begin
        j = $urandom_range(0, 3);
        return (adp_ip[j] & adp_mask[j]) | ($urandom() & ~adp_mask[j]);
      end
      4: return adp_ip[$urandom_range(0, 3)];
      5, 6: begin
        if (rt_cnt == 0) return $urandom();
        j = $urandom_range(0, rt_cnt - 1);
        return ($urandom_range(0, 1)) ? rt_dest[j]
                                      : (rt_dest[j] & rt_mask[j]) | ($urandom() & ~rt_mask[j]);
      end
      7: begin
        if (arp_cnt == 0) return $urandom();
        return arp_ip[$urandom_range(0, arp_cnt - 1)];
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int k;
    k = $urandom_range(0, 99);
    w.func = (k < 14) ? FuncAddRoute : (k < 32) ? FuncAddArp : (k < 95) ? FuncGetRoute : FuncNone;
    w.ip = pick_ip();
    if (w.func == FuncAddRoute && $urandom_range(0, 4) == 0) w.ip = 32'h0;
    case ($urandom_range(0, 4))
      0: w.sg = 32'h0;
      1: w.sg = adp_ip[$urandom_range(0, 3)];
      2: w.sg = (arp_cnt > 0) ? arp_ip[$urandom_range(0, arp_cnt - 1)] : $urandom();
      default: w.sg = (w.func == FuncGetRoute) ? 32'h0 : pick_ip();
    endcase
    w.rmask = ($urandom_range(0, 3) == 0) ? $urandom() : prefix_mask($urandom_range(0, 32));
    w.mac = {$urandom(), $urandom()};
    if ($urandom_range(0, 15) == 0) w.mac = ($urandom_range(0, 1)) ? '1 : '0;
    w.idx = $urandom_range(0, 3);
    w.given = $urandom_range(0, 2) == 0;
    w.bcast = $urandom_range(0, 1);
    if (w.func == FuncAddArp && rt_cnt > 0 && $urandom_range(0, 1))
      w.ip = rt_gw[$urandom_range(0, rt_cnt - 1)];
    return w;
  endfunction

  // Offer one word after a random gap, record its answer at acceptance
  task automatic send_word(word_t w, logic typed, answer_t ans);
    int gap;
    answer_t predicted;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cur <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = lookup_answer(w);
    pending_answers.insert(pending_answers.size(), typed ? ans : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic apb_write(int idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx[0]) adp_mask[idx >> 1] = val;
    else adp_ip[idx >> 1] = val;
    @(posedge clk);
  endtask

  // Adapter settings per phase, extremes included
  task automatic set_adapters(int ph);
    logic [31:0] ip, m;
    for (int a = 0; a < 4; a++) begin
      case (ph)
        0: begin ip = 32'h0; m = 32'h0; end
        1: begin
          ip = (a == 0) ? 32'hC0A8_0001 : (a == 1) ? 32'h0A00_00FE
             : (a == 2) ? 32'hAC10_0501 : 32'h0;
          m = (a == 0) ? 32'hFFFF_FF00 : (a == 1) ? 32'hFF00_0000
            : (a == 2) ? 32'hFFFF_0000 : 32'h0;
        end
        2: begin ip = 32'hFFFF_FFFF; m = 32'hFFFF_FFFF; end
        3: begin ip = $urandom(); m = prefix_mask($urandom_range(8, 30)); end
        4: begin ip = $urandom(); m = 32'h0; end
        default: begin ip = $urandom(); m = $urandom(); end
      endcase
      apb_write(2 * a, ip);
      apb_write(2 * a + 1, m);
    end
  endtask

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) k = 0;
      if (hold_req) begin
        k = HoldCycles;
        hold_req = 1'b0;
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker and idle watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    answer_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $error("unexpected result word, status %0d", status);
          errors++;
        end else begin
          e = pending_answers.pop_front();
          if (status !== e.st) begin
            $error("status: expected %0d actual %0d", e.st, status); errors++;
          end
          if (mac_out !== e.mac) begin
            $error("mac_out: expected %h actual %h", e.mac, mac_out); errors++;
          end
          if (out_adapter !== e.ad) begin
            $error("out_adapter: expected %0d actual %0d", e.ad, out_adapter); errors++;
          end
          if (out_adapter_valid !== e.adv) begin
            $error("out_adapter_valid: expected %0d actual %0d", e.adv, out_adapter_valid);
            errors++;
          end
          if (hop_addr !== e.hop) begin
            $error("hop_addr: expected %h actual %h", e.hop, hop_addr); errors++;
          end
        end
      end
    end
  end

  initial begin
    answer_t ok0, none;
    ok0 = mk_ans(StOk, '0, '0, 1'b0, '0);
    none = mk_ans(StNoRoute, '0, '0, 1'b0, '0);
    // Adapter registers come out of reset as zero
    for (int a = 0; a < 4; a++) begin
      adp_ip[a] = '0;
      adp_mask[a] = '0;
    end
    // Directed table; typed answers only where obvious
    add_row({mk_word(FuncGetRoute, 32'h0102_0304, 0, 0, 0, 0, 0, 0), 1'b1, none});
    add_row({mk_word(FuncGetRoute, 32'h0, 0, 0, 0, 0, 0, 1),
             1'b1, mk_ans(StLoopback, '0, '0, 1'b0, '0)});
    add_row({mk_word(FuncNone, '1, '1, '1, '1, 3, 1, 1), 1'b1, ok0});
    add_row({mk_word(FuncAddArp, 32'hC0A8_0001, 0, 0, '1, 0, 0, 0), 1'b1, ok0});
    add_row({mk_word(FuncAddArp, 32'hC0A8_0001, 0, 0, 48'h1, 0, 0, 0),
             1'b1, mk_ans(StDup, '0, '0, 1'b0, '0)});
    add_row({mk_word(FuncAddArp, '1, 0, 0, '0, 0, 0, 0), 1'b1, ok0});
    add_row({mk_word(FuncAddRoute, 32'h0, 32'hC0A8_0001, 0, 0, 0, 0, 0), 1'b1, ok0});
    add_row({mk_word(FuncGetRoute, 32'h0808_0808, 0, 0, 0, 0, 0, 0), 1'b0, ok0});
    add_row({mk_word(FuncAddRoute, 32'h0A00_0000, 32'h0A00_0001, 32'hFF00_0000,
                     0, 1, 1, 0), 1'b1, ok0});
    add_row({mk_word(FuncGetRoute, 32'h0A01_0203, 0, 0, 0, 0, 0, 0), 1'b0, ok0});
    add_row({mk_word(FuncAddRoute, 32'h0A01_0000, 32'h0A01_0001, 32'hFFFF_0000,
                     0, 2, 1, 0), 1'b1, ok0});
    add_row({mk_word(FuncGetRoute, 32'h0A01_0909, 0, 0, 0, 0, 0, 0), 1'b0, ok0});
    add_row({mk_word(FuncAddRoute, 32'h0A01_0203, '1, '1, 0, 0, 0, 0), 1'b1, ok0});
    // exact route via an all-ones gateway that sits in the cache with MAC zero
    add_row({mk_word(FuncGetRoute, 32'h0A01_0203, 0, 0, 0, 0, 0, 0), 1'b1, ok0});
    add_row({mk_word(FuncGetRoute, '1, 0, 0, 0, 0, 0, 1), 1'b0, ok0});
    add_row({mk_word(FuncGetRoute, '1, 0, 0, 0, 3, 1, 1), 1'b0, ok0});
    add_row({mk_word(FuncAddRoute, 32'h0, '1, 32'h0, 0, 3, 1, 0), 1'b1, ok0});
    add_row({mk_word(FuncGetRoute, 32'h0808_0808, 0, 0, 0, 3, 1, 0), 1'b0, ok0});
    add_row({mk_word(FuncGetRoute, 32'h0A02_0000, '1, 0, 0, 1, 1, 0), 1'b0, ok0});
    add_row({mk_word(FuncAddArp, 32'h0A00_0001, 0, 0, 48'h0200_0000_0001,
                     0, 0, 0), 1'b1, ok0});
    add_row({mk_word(FuncGetRoute, 32'h0A7F_0001, 0, 0, 0, 1, 1, 0), 1'b0, ok0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].ans);
    drain();

    // Random phases; the sender pauses between them until all answers are in
    for (int ph = 0; ph < 6; ph++) begin
      set_adapters(ph);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) send_word(rand_word(), 1'b0, ok0);
      drain();
    end

    repeat (60) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/rlac_pkg.sv
rtl/core/route_lookup_arp_cache_unit.sv
bench/tb_route_lookup_arp_cache_unit.sv
